// ----- sv/rtspdf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtspdf_pkg
// Shared types, byte codes and the header field-name table for the RTSP
// interleaved deframer.
// ----------------------------------------------------------------------------
package rtspdf_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   localparam logic [3:0] NAME_LEN  = 4'd14;
   localparam logic [3:0] NAME_DEAD = 4'd15;

   localparam logic [2:0] MARK_NONE    = 3'd0;
   localparam logic [2:0] MARK_CR1     = 3'd1;
   localparam logic [2:0] MARK_LF1     = 3'd2;
   localparam logic [2:0] MARK_CR2     = 3'd3;
   localparam logic [2:0] MARK_DONE    = 3'd4;

   localparam int CALC_BITS = 20;

   typedef enum logic [1:0] {
      KIND_FRAME_HDR = 2'd0,
      KIND_PAYLOAD   = 2'd1,
      KIND_RTSP_HDR  = 2'd2,
      KIND_RTSP_BODY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      VP_IDLE   = 2'd0,
      VP_WAIT   = 2'd1,
      VP_DIGITS = 2'd2,
      VP_DONE   = 2'd3
   } value_phase_type;

   typedef struct packed {
      logic [2:0]      end_marker;
      logic [3:0]      name_match;
      value_phase_type value_phase;
      logic            at_line_start;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{
      end_marker:    MARK_NONE,
      name_match:    4'd0,
      value_phase:   VP_IDLE,
      at_line_start: 1'b1
   };

   function automatic logic [7:0] to_lower(input logic [7:0] b);
      to_lower = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
   endfunction

   // lower-case "content-length"
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      case (idx)
         4'd0:    name_char = 8'h63;
         4'd1:    name_char = 8'h6F;
         4'd2:    name_char = 8'h6E;
         4'd3:    name_char = 8'h74;
         4'd4:    name_char = 8'h65;
         4'd5:    name_char = 8'h6E;
         4'd6:    name_char = 8'h74;
         4'd7:    name_char = 8'h2D;
         4'd8:    name_char = 8'h6C;
         4'd9:    name_char = 8'h65;
         4'd10:   name_char = 8'h6E;
         4'd11:   name_char = 8'h67;
         4'd12:   name_char = 8'h74;
         4'd13:   name_char = 8'h68;
         default: name_char = 8'h00;
      endcase
   endfunction

endpackage
`default_nettype wire

// ----- sv/rtspdf_field_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtspdf_field_scan
// Per-byte header scanner: end-of-header marker, Content-Length name match
// and saturating decimal value capture.
// ----------------------------------------------------------------------------
module rtspdf_field_scan
   import rtspdf_pkg::*;
#(
   parameter int LENGTH_BITS = 16,
   parameter int BODY_BITS   = 16
) (
   input  wire logic [7:0]           data_byte,
   input  wire logic [15:0]          max_body_len,
   input  wire scan_state_type       scan_cur,
   input  wire logic [BODY_BITS-1:0] body_cur,
   output scan_state_type            scan_next,
   output logic [BODY_BITS-1:0]      body_next,
   output logic                      end_found
);

   localparam logic [15:0] LEN_CAP =
      (LENGTH_BITS >= 16) ? 16'hFFFF : 16'((64'd1 << LENGTH_BITS) - 64'd1);

   logic [2:0]           mark_in;
   logic                 digit;
   logic [3:0]           digit_val;
   logic [15:0]          limit;
   logic [CALC_BITS-1:0] acc;
   logic [CALC_BITS-1:0] val_sel;
   logic [CALC_BITS-1:0] val_cap;
   logic [3:0]           name_cur;

   always_comb begin
      if (data_byte == CHAR_CR) begin
         mark_in = (scan_cur.end_marker == MARK_LF1) ? MARK_CR2 : MARK_CR1;
      end else if (data_byte == CHAR_LF &&
                   (scan_cur.end_marker == MARK_CR1 || scan_cur.end_marker == MARK_CR2)) begin
         mark_in = scan_cur.end_marker + 3'd1;
      end else begin
         mark_in = MARK_NONE;
      end
      end_found = (mark_in == MARK_DONE);

      digit     = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
      digit_val = 4'(data_byte - CHAR_ZERO);
      limit     = (max_body_len > LEN_CAP) ? LEN_CAP : max_body_len;
      acc       = CALC_BITS'({body_cur, 3'b000}) + CALC_BITS'({body_cur, 1'b0})
                  + CALC_BITS'(digit_val);
      val_sel   = (scan_cur.value_phase == VP_WAIT) ? CALC_BITS'(digit_val) : acc;
      val_cap   = (val_sel > CALC_BITS'(limit)) ? CALC_BITS'(limit) : val_sel;

      scan_next            = scan_cur;
      scan_next.end_marker = end_found ? MARK_NONE : mark_in;
      body_next            = body_cur;

      case (scan_cur.value_phase)
         VP_WAIT: begin
            if (digit) begin
               body_next             = BODY_BITS'(val_cap);
               scan_next.value_phase = VP_DIGITS;
            end else if (data_byte != CHAR_SPACE && data_byte != CHAR_TAB) begin
               scan_next.value_phase = VP_DONE;
            end
         end
         VP_DIGITS: begin
            if (digit) begin
               body_next = BODY_BITS'(val_cap);
            end else begin
               scan_next.value_phase = VP_DONE;
            end
         end
         default: begin
         end
      endcase

      name_cur = scan_cur.at_line_start ? 4'd0 : scan_cur.name_match;
      if (name_cur < NAME_LEN) begin
         scan_next.name_match = (to_lower(data_byte) == name_char(name_cur)) ?
                                name_cur + 4'd1 : NAME_DEAD;
      end else if (name_cur == NAME_LEN) begin
         if (data_byte == CHAR_COLON || data_byte == CHAR_SPACE) begin
            scan_next.value_phase = VP_WAIT;
            body_next             = '0;
         end
         scan_next.name_match = NAME_DEAD;
      end else begin
         scan_next.name_match = name_cur;
      end
      scan_next.at_line_start = (data_byte == CHAR_LF);
   end

endmodule
`default_nettype wire

// ----- sv/rtsp_interleaved_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtsp_interleaved_deframer
// Classifies each byte of an RTSP control stream carrying interleaved RTP
// frames and echoes it with kind, channel and message marks.
// ----------------------------------------------------------------------------
// result: each accepted input word gives its result word in the next cycle
// throughput: one word per cycle unless rsp_tready holds back a full result register;
//   the result register is freed by rsp_tready in the same cycle it is refilled
// reset: synchronous, active high; parser returns to message start, limits
//   return to 4095 header bytes and 65535 body bytes
module rtsp_interleaved_deframer
   import rtspdf_pkg::*;
#(
   parameter int LENGTH_BITS       = 16,
   parameter int HEADER_COUNT_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_byte, frame_channel
   output logic [3:0]       rsp_tuser,   // byte_kind, first_of_message, framing_error
   output logic             rsp_tlast    // last_of_message
);

   localparam int RW  = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
   localparam int BW  = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
   localparam int HCB = HEADER_COUNT_BITS;
   localparam int CW  = (HCB > 12) ? HCB : 12;
   localparam logic [RW-1:0]  REM_MASK = RW'((64'd1 << LENGTH_BITS) - 64'd1);
   localparam logic [HCB-1:0] HCNT_MAX = '1;

   localparam logic [0:0] REG_MAX_HEADER = 1'd0;
   localparam logic [0:0] REG_MAX_BODY   = 1'd1;

   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_CHAN    = 3'd1,
      PH_LENHI   = 3'd2,
      PH_LENLO   = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_HEADER  = 3'd5,
      PH_BODY    = 3'd6
   } phase_type;

   logic [11:0]     max_header_ff;
   logic [15:0]     max_body_ff;

   phase_type       phase_ff, phase_in;
   scan_state_type  scan_ff, scan_in;
   logic [BW-1:0]   body_ff, body_in;
   logic [RW-1:0]   remain_ff, remain_in;
   logic [7:0]      chan_ff, chan_in;
   logic [HCB-1:0]  hcount_ff, hcount_in;

   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic [7:0]      rsp_chan_ff, rsp_chan_in;
   kind_type        rsp_kind_ff, rsp_kind_in;
   logic            rsp_first_ff, rsp_first_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            rsp_err_ff, rsp_err_in;

   logic            req_fire;
   logic            in_header;
   logic            from_header;
   scan_state_type  scan_cur, scan_next;
   logic [BW-1:0]   body_cur, body_next;
   logic [HCB-1:0]  hc_cur, hc_next;
   logic            end_found;
   logic [RW-1:0]   remain_dec;
   logic [RW-1:0]   remain_lo;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign from_header = (phase_ff == PH_HEADER);
   assign scan_cur    = from_header ? scan_ff : SCAN_CLEAR;
   assign body_cur    = from_header ? body_ff : '0;
   assign hc_cur      = from_header ? hcount_ff : '0;
   assign hc_next     = (hc_cur < HCNT_MAX) ? hc_cur + 1'b1 : hc_cur;
   assign remain_dec  = (remain_ff - 1'b1) & REM_MASK;
   assign remain_lo   = RW'({remain_ff[15:8], req_tdata});

   rtspdf_field_scan #(
      .LENGTH_BITS (LENGTH_BITS),
      .BODY_BITS   (BW)
   ) u_scan (
      .data_byte    (req_tdata),
      .max_body_len (max_body_ff),
      .scan_cur     (scan_cur),
      .body_cur     (body_cur),
      .scan_next    (scan_next),
      .body_next    (body_next),
      .end_found    (end_found)
   );

   always_comb begin
      phase_in     = phase_ff;
      scan_in      = scan_ff;
      body_in      = body_ff;
      remain_in    = remain_ff;
      chan_in      = chan_ff;
      hcount_in    = hcount_ff;
      rsp_kind_in  = KIND_FRAME_HDR;
      rsp_chan_in  = 8'd0;
      rsp_first_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_err_in   = 1'b0;
      in_header    = 1'b0;

      case (phase_ff)
         PH_CHAN: begin
            chan_in     = req_tdata;
            rsp_chan_in = req_tdata;
            phase_in    = PH_LENHI;
         end
         PH_LENHI: begin
            rsp_chan_in = chan_ff;
            remain_in   = RW'({req_tdata, 8'h00});
            phase_in    = PH_LENLO;
         end
         PH_LENLO: begin
            rsp_chan_in = chan_ff;
            remain_in   = remain_lo;
            if (remain_lo == '0) begin
               rsp_last_in = 1'b1;
               phase_in    = PH_START;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            rsp_kind_in = KIND_PAYLOAD;
            rsp_chan_in = chan_ff;
            remain_in   = remain_dec;
            if (remain_dec == '0) begin
               rsp_last_in = 1'b1;
               phase_in    = PH_START;
            end
         end
         PH_HEADER: begin
            in_header = 1'b1;
         end
         PH_BODY: begin
            rsp_kind_in = KIND_RTSP_BODY;
            remain_in   = remain_dec;
            if (remain_dec == '0) begin
               rsp_last_in = 1'b1;
               phase_in    = PH_START;
            end
         end
         default: begin
            rsp_first_in = 1'b1;
            scan_in      = SCAN_CLEAR;
            body_in      = '0;
            hcount_in    = '0;
            if (req_tdata == CHAR_DOLLAR) begin
               phase_in = PH_CHAN;
            end else begin
               in_header = 1'b1;
            end
         end
      endcase

      if (in_header) begin
         rsp_kind_in = KIND_RTSP_HDR;
         rsp_chan_in = 8'd0;
         hcount_in   = hc_next;
         scan_in     = scan_next;
         body_in     = body_next;
         phase_in    = PH_HEADER;
         if (end_found) begin
            if (body_next == '0) begin
               rsp_last_in = 1'b1;
               phase_in    = PH_START;
            end else begin
               remain_in = RW'(body_next);
               phase_in  = PH_BODY;
            end
         end else if (CW'(hc_next) >= CW'(max_header_ff)) begin
            rsp_err_in  = 1'b1;
            rsp_last_in = 1'b1;
            phase_in    = PH_START;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_header_ff <= 12'd4095;
         max_body_ff   <= 16'd65535;
         phase_ff      <= PH_START;
         scan_ff       <= SCAN_CLEAR;
         body_ff       <= '0;
         remain_ff     <= '0;
         chan_ff       <= 8'd0;
         hcount_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MAX_HEADER: max_header_ff <= csr_wdata[11:0];
               REG_MAX_BODY:   max_body_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            scan_ff      <= scan_in;
            body_ff      <= body_in;
            remain_ff    <= remain_in;
            chan_ff      <= chan_in;
            hcount_ff    <= hcount_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_byte_ff  <= req_tdata;
         rsp_chan_ff  <= rsp_chan_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_first_ff <= rsp_first_in;
         rsp_last_ff  <= rsp_last_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_chan_ff, rsp_byte_ff};
   assign rsp_tuser  = {rsp_err_ff, rsp_first_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   // a dollar at message start always opens a frame
   a_dollar_opens_frame: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_START && req_tdata == CHAR_DOLLAR |=> phase_ff == PH_CHAN)
      else $error("dollar at message start did not open a frame");

   // every accepted word produces a result word
   a_fire_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   // an overrun is only flagged on a header byte that closes the message
   a_error_is_last_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && rsp_kind_ff == KIND_RTSP_HDR)
      else $error("framing error outside a closing header byte");

   // first byte of a message is either the frame dollar or a header byte
   a_first_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_first_ff |->
         rsp_kind_ff == KIND_FRAME_HDR || rsp_kind_ff == KIND_RTSP_HDR)
      else $error("message start with wrong byte kind");

   // end marker match never holds the completed code
   a_marker_range: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> scan_ff.end_marker != MARK_DONE)
      else $error("end marker left in completed state");

endmodule
`default_nettype wire
